// ===== rtl/core/pfa_pkg.sv =====
`timescale 1ns / 1ps
package pfa_pkg;
  localparam int NumFrames = 64;
  localparam int MaxProcs = 16;
  localparam int FrameW = $clog2(NumFrames);
  localparam int CountW = $clog2(NumFrames + 1);
  localparam int SlotW = $clog2(MaxProcs);
  localparam int MemW = 24;
  localparam int FsW = 16;
  localparam int IdW = 16;
  localparam int WasteW = 20;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegTotalMemory = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameSize = 1'b1;

  localparam int ResetTotalMemory = 1024;
  localparam int ResetFrameSize = 64;
  localparam int ResetFrames = (ResetTotalMemory / ResetFrameSize > NumFrames)
                               ? NumFrames : ResetTotalMemory / ResetFrameSize;

  typedef enum logic [1:0] {
    StOk = 2'd0,
    StNoFrames = 2'd1,
    StNotFound = 2'd2,
    StTableFull = 2'd3
  } status_e;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdDelete = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // latch the command
    logic init;      // start re-init (frame count division)
    logic div_start; // start ceil division of size
    logic scan_clr;  // reset frame scan pointer
    logic scan_step; // advance frame scan
    logic slot_step; // advance slot scan
    logic commit_ins;
    logic commit_del;
    logic clr_map;   // clear map and table
  } pfa_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_done;
    logic slot_done;    // slot scan at end
    logic slot_hit;     // current slot matches
    logic fits;         // need <= free, and not oversized
    logic need_zero;
    logic scan_end;     // frame scan finished
    logic scan_free;    // current frame free
    logic alloc_last;   // this claim finishes need
    logic is_delete;
  } pfa_sts_t;
endpackage

// ===== rtl/core/paged_frame_allocator_unit.sv =====
`timescale 1ns / 1ps
// Paged frame allocator. A command is taken when start_i is high and busy_o low, and
// start_i wins over a configuration write offered in the same cycle. Results come out
// one per cycle on result_valid_o and cannot be stalled, so the receiver must take
// every one. An insert runs the slot scan, the ceiling division (one quotient bit per
// cycle) and the fit check, then examines frames in order up to the frame count, at
// most 64: a frame result leaves on each free frame claimed. A delete runs the slot
// scan, then frees all of its frames at once. A configuration write re-initializes
// everything and keeps busy_o high while the frame count is divided out.
module paged_frame_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cmd_i,
  input  logic [15:0] proc_id_i,
  input  logic [23:0] proc_size_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [pfa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic        frame_valid_o,
  output logic [5:0]  frame_o,
  output logic        last_o,
  output logic [6:0]  free_frames_o,
  output logic [19:0] total_fragmentation_o
);
  pfa_pkg::pfa_cmd_t cmd;
  pfa_pkg::pfa_sts_t sts;
  pfa_pkg::status_e st;
  logic [23:0] tmem_q;
  logic [15:0] fsize_q;
  logic cfg_wr, found, fv;
  logic [5:0] frame;
  logic [6:0] free;
  logic [19:0] waste;

  // hold off configuration while a command is offered
  assign cfg_ready_o = !busy_o && !start_i;
  assign cfg_wr = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmem_q <= 24'(pfa_pkg::ResetTotalMemory);
      fsize_q <= 16'(pfa_pkg::ResetFrameSize);
    end else if (cfg_wr) begin
      if (cfg_index_i == pfa_pkg::RegTotalMemory) tmem_q <= cfg_data_i[23:0];
      else fsize_q <= cfg_data_i[15:0];
    end
  end

  pfa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start_i),
    .cfg_wr_i(cfg_wr),
    .found_i(found),
    .sts_i(sts),
    .cmd_o(cmd),
    .busy_o,
    .strobe_o(result_valid_o),
    .status_o(st),
    .fvalid_o(fv),
    .last_o
  );

  pfa_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .sts_o(sts),
    .cmd_in_i(cmd_i), .proc_id_i, .proc_size_i,
    .total_memory_i(tmem_q), .frame_size_i(fsize_q),
    .frame_o(frame), .free_o(free), .waste_o(waste),
    .slot_found_o(found)
  );

  // Frame number of the claim registered alongside the strobe.
  logic [5:0] frame_q;
  always_ff @(posedge clk_i) frame_q <= frame;

  assign status_o = st;
  assign frame_valid_o = fv;
  assign frame_o = fv ? frame_q : 6'd0;
  assign free_frames_o = free;
  assign total_fragmentation_o = waste;
endmodule

// ===== rtl/core/pfa_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 24-bit dividend by 16-bit divisor.
module pfa_divider (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [pfa_pkg::MemW-1:0] dividend_i,
  input  logic [pfa_pkg::FsW-1:0]  divisor_i,
  output logic                    done_o,
  output logic [pfa_pkg::MemW-1:0] quot_o,
  output logic [pfa_pkg::FsW-1:0]  rem_o
);
  logic [pfa_pkg::MemW-1:0] q_q, q_d;
  logic [pfa_pkg::FsW:0] r_q, r_d;
  logic [pfa_pkg::FsW-1:0] dv_q;
  logic [4:0] cnt_q;
  logic busy_q;
  logic [pfa_pkg::FsW:0] trial;

  always_comb begin
    trial = {r_q[pfa_pkg::FsW-1:0], q_q[pfa_pkg::MemW-1]};
    q_d = {q_q[pfa_pkg::MemW-2:0], 1'b0};
    r_d = trial;
    if (trial >= {1'b0, dv_q}) begin
      r_d = trial - {1'b0, dv_q};
      q_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 5'(pfa_pkg::MemW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      dv_q <= divisor_i;
    end else if (busy_q) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign quot_o = q_q;
  assign rem_o = r_q[pfa_pkg::FsW-1:0];
endmodule

// ===== rtl/core/pfa_datapath.sv =====
`timescale 1ns / 1ps
module pfa_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pfa_pkg::pfa_cmd_t          cmd_i,
  output pfa_pkg::pfa_sts_t          sts_o,
  input  logic                       cmd_in_i,
  input  logic [pfa_pkg::IdW-1:0]    proc_id_i,
  input  logic [pfa_pkg::MemW-1:0]   proc_size_i,
  input  logic [pfa_pkg::MemW-1:0]   total_memory_i,
  input  logic [pfa_pkg::FsW-1:0]    frame_size_i,
  output logic [pfa_pkg::FrameW-1:0] frame_o,
  output logic [pfa_pkg::CountW-1:0] free_o,
  output logic [pfa_pkg::WasteW-1:0] waste_o,
  output logic                       slot_found_o
);
  localparam int NF = pfa_pkg::NumFrames;
  localparam int MP = pfa_pkg::MaxProcs;

  // Frame map: one in-use bit per frame, and per slot the set of frames it owns.
  logic [NF-1:0] used_q;
  logic [NF-1:0] smap_q [MP];
  logic [MP-1:0] valid_q;
  logic [pfa_pkg::IdW-1:0] sid_q [MP];
  logic [pfa_pkg::CountW-1:0] sfr_q [MP];
  logic [pfa_pkg::FsW-1:0] swaste_q [MP];

  logic del_q;
  logic [pfa_pkg::IdW-1:0] id_q;
  logic [pfa_pkg::MemW-1:0] size_q;
  logic [pfa_pkg::SlotW:0] slot_q;
  logic [pfa_pkg::SlotW-1:0] tgt_q;
  logic found_q;
  logic [pfa_pkg::CountW-1:0] ftotal_q, free_q, need_q, n_q;
  logic [pfa_pkg::WasteW-1:0] wtot_q;
  logic [pfa_pkg::FsW-1:0] waste_q;
  logic huge_q;
  logic [pfa_pkg::CountW:0] k_q;
  logic init_q;

  logic div_start, div_done;
  logic [pfa_pkg::MemW-1:0] quot;
  logic [pfa_pkg::FsW-1:0] rem;
  logic [pfa_pkg::SlotW-1:0] slot_idx;
  logic [pfa_pkg::FrameW-1:0] k_idx;

  assign div_start = cmd_i.div_start | cmd_i.init;
  pfa_divider u_div (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(cmd_i.init ? total_memory_i : size_q),
    .divisor_i (frame_size_i),
    .done_o    (div_done),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  assign slot_idx = slot_q[pfa_pkg::SlotW-1:0];
  assign k_idx = k_q[pfa_pkg::FrameW-1:0];

  always_comb begin
    sts_o = '0;
    sts_o.div_done = div_done;
    sts_o.slot_done = slot_q[pfa_pkg::SlotW];
    sts_o.slot_hit = del_q ? (valid_q[slot_idx] && sid_q[slot_idx] == id_q)
                           : !valid_q[slot_idx];
    sts_o.fits = !huge_q && need_q <= free_q;
    sts_o.need_zero = need_q == '0;
    // a delete frees all its frames at once, so it has no scan
    sts_o.scan_end = del_q ? 1'b1 : (k_q >= {1'b0, ftotal_q});
    sts_o.scan_free = !used_q[k_idx];
    sts_o.alloc_last = n_q + 1'b1 == need_q;
    sts_o.is_delete = del_q;
  end

  assign frame_o = k_idx;
  assign free_o = free_q;
  assign waste_o = wtot_q;
  assign slot_found_o = found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q <= '0;
      ftotal_q <= pfa_pkg::CountW'(pfa_pkg::ResetFrames);
      free_q <= pfa_pkg::CountW'(pfa_pkg::ResetFrames);
      wtot_q <= '0;
      init_q <= 1'b0;
      slot_q <= '0;
      tgt_q <= '0;
      found_q <= 1'b0;
      k_q <= '0;
      n_q <= '0;
    end else begin
      if (cmd_i.clr_map) begin
        valid_q <= '0;
        used_q <= '0;
        wtot_q <= '0;
        init_q <= 1'b1;
      end
      if (init_q && div_done) begin
        init_q <= 1'b0;
        if (frame_size_i == '0) begin
          ftotal_q <= '0; free_q <= '0;
        end else if (quot > pfa_pkg::MemW'(NF)) begin
          ftotal_q <= pfa_pkg::CountW'(NF); free_q <= pfa_pkg::CountW'(NF);
        end else begin
          ftotal_q <= quot[pfa_pkg::CountW-1:0];
          free_q <= quot[pfa_pkg::CountW-1:0];
        end
      end
      if (cmd_i.load) begin
        slot_q <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.slot_step) begin
        if (sts_o.slot_hit && !found_q) begin
          found_q <= 1'b1;
          tgt_q <= slot_idx;
          slot_q <= (pfa_pkg::SlotW+1)'(MP);
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
      if (cmd_i.scan_clr) begin
        k_q <= '0;
        n_q <= '0;
      end else if (cmd_i.scan_step) begin
        k_q <= k_q + 1'b1;
        if (sts_o.scan_free) begin
          used_q[k_idx] <= 1'b1;
          n_q <= n_q + 1'b1;
        end
      end
      if (cmd_i.commit_ins) begin
        valid_q[tgt_q] <= 1'b1;
        free_q <= free_q - need_q;
        wtot_q <= wtot_q + pfa_pkg::WasteW'(waste_q);
      end
      if (cmd_i.commit_del) begin
        valid_q[tgt_q] <= 1'b0;
        used_q <= used_q & ~smap_q[tgt_q];
        free_q <= free_q + sfr_q[tgt_q];
        wtot_q <= wtot_q - pfa_pkg::WasteW'(swaste_q[tgt_q]);
      end
    end
  end

  // Latched command and ceil division result, kept until commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      del_q <= cmd_in_i == pfa_pkg::CmdDelete;
      id_q <= proc_id_i;
      size_q <= proc_size_i;
    end
    if (div_done && !init_q) begin
      if (frame_size_i == '0) begin
        need_q <= '0;
        huge_q <= size_q != '0;
        waste_q <= '0;
      end else begin
        huge_q <= (quot + ((rem != '0) ? 1'b1 : 1'b0)) > pfa_pkg::MemW'(NF);
        need_q <= pfa_pkg::CountW'(quot + ((rem != '0) ? 1'b1 : 1'b0));
        waste_q <= (rem != '0) ? frame_size_i - rem : '0;
      end
    end
    if (cmd_i.commit_ins) begin
      sid_q[tgt_q] <= id_q;
      sfr_q[tgt_q] <= need_q;
      swaste_q[tgt_q] <= waste_q;
      smap_q[tgt_q] <= '0;
    end else if (cmd_i.scan_step && sts_o.scan_free) begin
      smap_q[tgt_q][k_idx] <= 1'b1;
    end
  end
endmodule

// ===== rtl/core/pfa_ctrl.sv =====
`timescale 1ns / 1ps
module pfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              cfg_wr_i,
  input  logic              found_i,
  input  pfa_pkg::pfa_sts_t sts_i,
  output pfa_pkg::pfa_cmd_t cmd_o,
  output logic              busy_o,
  output logic              strobe_o,
  output pfa_pkg::status_e  status_o,
  output logic              fvalid_o,
  output logic              last_o
);
  typedef enum logic [2:0] {
    SIdle, SInit, SSlot, SDiv, SFit, SScan, SDel, SDone
  } state_e;
  state_e state_q;
  logic busy_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = start_i && !busy_q;
    cmd_o.clr_map = cfg_wr_i;
    cmd_o.init = state_q == SInit;
    cmd_o.slot_step = state_q == SSlot && !sts_i.slot_done;
    cmd_o.div_start = state_q == SSlot && sts_i.slot_done && found_i && !sts_i.is_delete;
    cmd_o.scan_clr = state_q == SDiv || (state_q == SSlot && sts_i.slot_done);
    cmd_o.scan_step = (state_q == SScan || state_q == SDel) && !sts_i.scan_end;
    cmd_o.commit_ins = state_q == SFit && sts_i.fits;
    cmd_o.commit_del = state_q == SDel && sts_i.scan_end;
  end

  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      busy_q <= 1'b0;
      strobe_o <= 1'b0;
      status_o <= pfa_pkg::StOk;
      fvalid_o <= 1'b0;
      last_o <= 1'b0;
    end else begin
      strobe_o <= 1'b0;
      fvalid_o <= 1'b0;
      last_o <= 1'b0;
      status_o <= pfa_pkg::StOk;
      case (state_q)
        SIdle: begin
          if (cfg_wr_i) begin
            state_q <= SInit;
            busy_q <= 1'b1;
          end else if (start_i) begin
            state_q <= SSlot;
            busy_q <= 1'b1;
          end
        end
        SInit: state_q <= SDone;
        SDone: begin
          // wait for frame count division
          if (sts_i.div_done) begin
            state_q <= SIdle;
            busy_q <= 1'b0;
          end
        end
        SSlot: begin
          if (sts_i.slot_done) begin
            if (!found_i) begin
              strobe_o <= 1'b1;
              last_o <= 1'b1;
              status_o <= sts_i.is_delete ? pfa_pkg::StNotFound : pfa_pkg::StTableFull;
              state_q <= SIdle;
              busy_q <= 1'b0;
            end else if (sts_i.is_delete) begin
              state_q <= SDel;
            end else begin
              state_q <= SDiv;
            end
          end
        end
        // frame need is registered at the end of the division
        SDiv: begin
          if (sts_i.div_done) state_q <= SFit;
        end
        SFit: begin
          if (!sts_i.fits || sts_i.need_zero) begin
            strobe_o <= 1'b1;
            last_o <= 1'b1;
            status_o <= sts_i.fits ? pfa_pkg::StOk : pfa_pkg::StNoFrames;
            state_q <= SIdle;
            busy_q <= 1'b0;
          end else begin
            state_q <= SScan;
          end
        end
        SScan: begin
          if (sts_i.scan_end) begin
            state_q <= SIdle;
            busy_q <= 1'b0;
          end else if (sts_i.scan_free) begin
            strobe_o <= 1'b1;
            fvalid_o <= 1'b1;
            last_o <= sts_i.alloc_last;
            if (sts_i.alloc_last) begin
              state_q <= SIdle;
              busy_q <= 1'b0;
            end
          end
        end
        SDel: begin
          if (sts_i.scan_end) begin
            strobe_o <= 1'b1;
            last_o <= 1'b1;
            state_q <= SIdle;
            busy_q <= 1'b0;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) strobe_o && !fvalid_o |-> last_o)
    else $error("non-frame result must be last");
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q != SIdle |-> busy_q)
    else $error("busy low while working");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.commit_ins |-> !cmd_o.commit_del)
    else $error("double commit");
endmodule
